[rtl/cvl_pkg.sv]
// ----------------------------------------------------------------------------
// cvl_pkg: shared definitions for the circular value list
// Sizes, operation and status codes, controller states and the control
// word that the controller hands to the row of value cells.
// ----------------------------------------------------------------------------
package cvl_pkg;

   localparam int CAPACITY = 32;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_UPDATE = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_DUMP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DUMP,
      S_REPORT
   } state_type;

   // Per-cycle command to the cell row
   typedef struct packed {
      logic              shift;      // every cell but the last takes its right neighbour
      logic              tail_load;  // cell at tail_idx takes tail_val
      logic [IDX_W-1:0]  tail_idx;
      logic [DATA_W-1:0] tail_val;
      logic              head_load;  // cell 0 takes head_val (wins over tail)
      logic [DATA_W-1:0] head_val;
   } chain_ctl_type;

endpackage

[rtl/cvl_cell.sv]
// ----------------------------------------------------------------------------
// cvl_cell: one value cell of the ring
// Holds one stored value; loads a given word, takes its neighbour's value
// on a shift, or holds.
// ----------------------------------------------------------------------------
module cvl_cell (
   input  logic                       clock,
   input  logic                       load,
   input  logic [cvl_pkg::DATA_W-1:0] load_val,
   input  logic                       shift,
   input  logic [cvl_pkg::DATA_W-1:0] nbr_val,
   output logic [cvl_pkg::DATA_W-1:0] val
);
   import cvl_pkg::*;

   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (load) begin
         val_in = load_val;
      end else if (shift) begin
         val_in = nbr_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

[rtl/cvl_ctrl.sv]
// ----------------------------------------------------------------------------
// cvl_ctrl: sequencer of the circular value list
// Takes request words, walks the cell row one position a cycle (a dump only
// while the response is free) and drives the registered response word.
// ----------------------------------------------------------------------------
module cvl_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [cvl_pkg::DATA_W-1:0]        req_key,
   input  logic [cvl_pkg::DATA_W-1:0]        req_new_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [cvl_pkg::DATA_W-1:0]        rsp_item_value,
   output logic                              rsp_is_last,
   input  logic [cvl_pkg::DATA_W-1:0]        head_val,
   output cvl_pkg::chain_ctl_type            ctl
);
   import cvl_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic              found_ff, found_in;
   kind_type          kind_ff, kind_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] nv_ff, nv_in;
   status_type        status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_item_ff, rsp_item_in;
   logic              rsp_last_ff, rsp_last_in;

   kind_type          req_kind_t;
   logic              out_free;
   logic              hit;
   logic              last_step;

   assign req_kind_t = kind_type'(req_kind);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign hit        = !found_ff && (head_val == key_ff);
   assign last_step  = (step_ff == CNT_W'(1));
   assign req_ready  = (state_ff == S_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind_t == KIND_INSERT || count_ff == '0) begin
                  state_in = S_REPORT;
               end else if (req_kind_t == KIND_DUMP) begin
                  state_in = S_DUMP;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (last_step) begin
               state_in = S_REPORT;
            end
         end
         S_DUMP: begin
            if (out_free && last_step) begin
               state_in = S_IDLE;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      ctl           = '0;
      count_in      = count_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      nv_in         = nv_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind_t;
               key_in    = req_key;
               nv_in     = req_new_value;
               step_in   = count_ff;
               found_in  = 1'b0;
               status_in = STAT_OK;
               case (req_kind_t)
                  KIND_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        // new value becomes entry, old entry moves to the end
                        ctl.head_load = 1'b1;
                        ctl.head_val  = req_new_value;
                        ctl.tail_load = (count_ff != '0);
                        ctl.tail_idx  = count_ff[IDX_W-1:0];
                        ctl.tail_val  = head_val;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = STAT_NOT_FOUND;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            ctl.shift    = 1'b1;
            ctl.tail_idx = IDX_W'(count_ff - CNT_W'(1));
            if (kind_ff == KIND_DELETE) begin
               // drop the matching value: the ring shortens by one
               ctl.tail_load = !hit;
               ctl.tail_val  = head_val;
               if (hit) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               ctl.tail_load = 1'b1;
               ctl.tail_val  = hit ? nv_ff : head_val;
            end
            found_in = found_ff || hit;
            step_in  = step_ff - CNT_W'(1);
            if (last_step) begin
               status_in = (found_ff || hit) ? STAT_OK : STAT_NOT_FOUND;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               ctl.shift     = 1'b1;
               ctl.tail_load = 1'b1;
               ctl.tail_idx  = IDX_W'(count_ff - CNT_W'(1));
               ctl.tail_val  = head_val;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_item_in   = head_val;
               rsp_last_in   = last_step;
               step_in       = step_ff - CNT_W'(1);
            end
         end
         S_REPORT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_item_in   = '0;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      found_ff      <= found_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      nv_ff         <= nv_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_value = rsp_item_ff;
   assign rsp_is_last    = rsp_last_ff;

endmodule

[rtl/circular_value_list_top.sv]
// ----------------------------------------------------------------------------
// circular_value_list_top: ordered ring of signed 32-bit values
// Insert, update, delete and in-order dump over a row of value cells that
// rotates one position a cycle under a small sequencer; a stalled dump waits.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   direction
//   request   req_valid/ready, kind, key, new_value   in
//   response  rsp_valid/ready, status, item_value,    out
//             is_last
//
// Timing: insert goes from idle straight to the report state; update and
//   delete first walk all n stored values, n the fill count, one position
//   per cycle. A dump gives n words, one per cycle while rsp_ready allows.
// Reset clears the fill count and the control state; cells need no clear.
// A stalled response holds the walk of a dump and the final report; a new
//   request is taken as soon as the sequencer is back in idle, even while
//   the last response word still waits in its register.
//
module circular_value_list_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_kind,
   input  logic signed [cvl_pkg::DATA_W-1:0]  req_key,
   input  logic signed [cvl_pkg::DATA_W-1:0]  req_new_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic signed [cvl_pkg::DATA_W-1:0]  rsp_item_value,
   output logic                               rsp_is_last
);
   import cvl_pkg::*;

   // Cell 0 always holds the entry; the stored values sit in ring order in
   // cells 0 .. n-1. Cells beyond the fill count hold stale data.
   chain_ctl_type     ctl;
   logic [DATA_W-1:0] cell_val [CAPACITY];
   logic [DATA_W-1:0] head_val;
   logic [DATA_W-1:0] rsp_item;

   assign head_val       = cell_val[0];
   assign rsp_item_value = rsp_item;

   cvl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_item_value (rsp_item),
      .rsp_is_last    (rsp_is_last),
      .head_val       (head_val),
      .ctl            (ctl)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              is_head;
      logic              is_tail;
      logic              load;
      logic [DATA_W-1:0] load_val;
      logic [DATA_W-1:0] nbr_val;

      // the head cell takes the new entry on insert; the tail cell closes
      // the ring on a rotation or takes the old entry on insert
      assign is_head  = ctl.head_load && (i == 0);
      assign is_tail  = ctl.tail_load && (ctl.tail_idx == IDX_W'(i));
      assign load     = is_head || is_tail;
      assign load_val = is_head ? ctl.head_val : ctl.tail_val;

      // the last cell has no neighbour: hold its own value
      if (i == CAPACITY - 1) begin : g_last
         assign nbr_val = cell_val[i];
      end else begin : g_mid
         assign nbr_val = cell_val[i+1];
      end

      cvl_cell u_cell (
         .clock    (clock),
         .load     (load),
         .load_val (load_val),
         .shift    (ctl.shift),
         .nbr_val  (nbr_val),
         .val      (cell_val[i])
      );
   end

endmodule
